// ----- rtl/b64_pkg.sv -----
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions of the base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

  // Depth of the job queue between the front and the back.
  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;

  // Padding character.
  localparam logic [7:0] PAD_CHAR = 8'h3d;

  // Direction codes.
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // One job: up to four results that a single input item releases.
  typedef struct packed {
    logic [2:0]      cnt;      // number of results, 1 to 4
    logic [3:0][7:0] data;     // data[0] leaves first
    logic            has;      // results carry data
    logic            msg_end;  // the last result closes the message
  } job_t;

  // Sextet to alphabet character.
  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] c;
    c = {2'b00, s};
    if (s < 6'd26) begin
      b64_char = c + 8'h41;
    end else if (s < 6'd52) begin
      b64_char = c + 8'h47;
    end else if (s < 6'd62) begin
      b64_char = c - 8'd4;
    end else if (s == 6'd62) begin
      b64_char = 8'h2b;
    end else begin
      b64_char = 8'h2f;
    end
  endfunction

  // Character to {valid, sextet}; padding and unknown codes are invalid.
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [7:0] s;
    s = 8'h00;
    if (c inside {[8'h41:8'h5a]}) begin
      s = c - 8'h41;
      b64_sextet = {1'b1, s[5:0]};
    end else if (c inside {[8'h61:8'h7a]}) begin
      s = c - 8'h47;
      b64_sextet = {1'b1, s[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      s = c + 8'd4;
      b64_sextet = {1'b1, s[5:0]};
    end else if (c == 8'h2b) begin
      b64_sextet = {1'b1, 6'd62};
    end else if (c == 8'h2f) begin
      b64_sextet = {1'b1, 6'd63};
    end else begin
      b64_sextet = 7'd0;
    end
  endfunction

  // Left-align k held sextets in a 24-bit word.
  function automatic logic [23:0] b64_align(input logic [23:0] acc, input logic [2:0] k);
    case (k)
      3'd4:    b64_align = acc;
      3'd3:    b64_align = {acc[17:0], 6'd0};
      3'd2:    b64_align = {acc[11:0], 12'd0};
      default: b64_align = {acc[5:0], 18'd0};
    endcase
  endfunction

endpackage

// ----- rtl/b64_front.sv -----
// ----------------------------------------------------------------------------
// b64_front
// Accepts items, keeps the group state and turns each item into a job.
// ----------------------------------------------------------------------------
module b64_front import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr,
  input  logic       cfg_dir,
  input  logic       accept,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  logic       job_full,
  output logic       job_push,
  output job_t       job
);

  logic        dir_r;
  logic [1:0]  fill_r, fill_nxt;
  logic [17:0] bits_r, bits_nxt;
  logic        stop_r, stop_nxt;

  logic [1:0]  held;
  logic [1:0]  cnt_e;
  logic [23:0] acc_e, v_e;
  logic [6:0]  sx;
  logic [23:0] acc_d, v_d;
  logic [2:0]  k_d;
  logic [2:0]  n_d;

  // Direction register and group state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= DIR_ENCODE;
      fill_r <= 2'd0;
      bits_r <= 18'd0;
      stop_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        dir_r <= cfg_dir;
      end
      fill_r <= fill_nxt;
      bits_r <= bits_nxt;
      stop_r <= stop_nxt;
    end
  end

  // Classify the item and build its job.
  always_comb begin
    fill_nxt = fill_r;
    bits_nxt = bits_r;
    stop_nxt = stop_r;
    job      = '0;
    job_push = 1'b0;

    // Encode path: up to two held bytes plus the new one.
    held  = (fill_r == 2'd3) ? 2'd2 : fill_r;
    cnt_e = held + 2'd1;
    acc_e = {bits_r[15:0], in_char};
    case (cnt_e)
      2'd1:    v_e = {acc_e[7:0], 16'd0};
      2'd2:    v_e = {acc_e[15:0], 8'd0};
      default: v_e = acc_e;
    endcase

    // Decode path: one sextet more, or a stop.
    sx    = b64_sextet(in_char);
    acc_d = {bits_r, sx[5:0]};
    k_d   = 3'd0;
    v_d   = 24'd0;
    n_d   = 3'd0;

    if (cfg_wr) begin
      fill_nxt = 2'd0;
      bits_nxt = 18'd0;
      stop_nxt = 1'b0;
    end else if (accept) begin
      if (dir_r == DIR_ENCODE) begin
        if (cnt_e != 2'd3 && !in_last) begin
          bits_nxt = acc_e[17:0];
          fill_nxt = cnt_e;
        end else begin
          for (int i = 0; i < 4; i++) begin
            job.data[i] = (3'(i) <= {1'b0, cnt_e}) ? b64_char(v_e[23 - 6*i -: 6]) : PAD_CHAR;
          end
          job.cnt     = 3'd4;
          job.has     = 1'b1;
          job.msg_end = in_last;
          job_push    = 1'b1;
          fill_nxt    = 2'd0;
          bits_nxt    = 18'd0;
        end
      end else begin
        if (stop_r) begin
          n_d = 3'd0;
        end else if (!sx[6]) begin
          // Padding or unknown character: flush k held sextets as k-1 bytes.
          k_d = {1'b0, fill_r};
          v_d = b64_align({6'd0, bits_r}, k_d);
          n_d = (k_d >= 3'd2) ? k_d - 3'd1 : 3'd0;
          fill_nxt = 2'd0;
          bits_nxt = 18'd0;
          stop_nxt = 1'b1;
        end else begin
          k_d = {1'b0, fill_r} + 3'd1;
          v_d = b64_align(acc_d, k_d);
          if (k_d == 3'd4) begin
            n_d      = 3'd3;
            fill_nxt = 2'd0;
            bits_nxt = 18'd0;
          end else if (!in_last) begin
            bits_nxt = acc_d[17:0];
            fill_nxt = k_d[1:0];
          end else begin
            n_d = k_d - 3'd1;
          end
        end
        if (n_d != 3'd0) begin
          job.cnt     = n_d;
          job.data[0] = v_d[23:16];
          job.data[1] = v_d[15:8];
          job.data[2] = v_d[7:0];
          job.has     = 1'b1;
          job.msg_end = in_last;
          job_push    = 1'b1;
        end else if (in_last) begin
          // Message end without data.
          job.cnt     = 3'd1;
          job.msg_end = 1'b1;
          job_push    = 1'b1;
        end
      end
      // Every message end clears the state.
      if (in_last) begin
        fill_nxt = 2'd0;
        bits_nxt = 18'd0;
        stop_nxt = 1'b0;
      end
    end
  end

  // The encoder never holds a full group of three bytes.
  a_enc_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (dir_r == DIR_ENCODE) |-> (fill_r != 2'd3))
    else $error("encoder holds three bytes");

  // A job is only pushed into a queue that has room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job pushed into a full queue");

  // A job is never empty.
  a_job_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (job.cnt != 3'd0 && job.cnt <= 3'd4))
    else $error("job with a bad result count");

endmodule

// ----- rtl/b64_job_fifo.sv -----
// ----------------------------------------------------------------------------
// b64_job_fifo
// Short queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module b64_job_fifo import b64_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic full,
  output logic nonempty
);

  job_t                 mem_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOB_PTR_W:0]   count_r;
  logic                 do_push, do_pop;

  assign full     = (count_r == (JOB_PTR_W + 1)'(JOB_DEPTH));
  assign nonempty = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rd_job   = mem_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // The fill count never passes the depth.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (JOB_PTR_W + 1)'(JOB_DEPTH))
    else $error("job queue overfilled");

  // Pointers agree with the fill count when empty.
  a_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("job queue pointers disagree");

endmodule

// ----- rtl/b64_back.sv -----
// ----------------------------------------------------------------------------
// b64_back
// Takes jobs from the queue and hands out their results one per cycle unless pop stalls.
// ----------------------------------------------------------------------------
module b64_back import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_avail,
  input  job_t       job_in,
  output logic       job_take,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_char,
  output logic       out_has_data,
  output logic       out_run_last,
  output logic       out_message_end
);

  job_t       cur_r;
  logic       cur_vld_r;
  logic [1:0] idx_r;
  logic       out_vld_r;
  logic [7:0] char_r;
  logic       has_r, run_last_r, msg_end_r;

  logic       out_load;
  logic       at_end;

  assign out_load = !out_vld_r || pop;
  assign at_end   = ({1'b0, idx_r} == cur_r.cnt - 3'd1);
  assign job_take = job_avail && (!cur_vld_r || (out_load && at_end));

  // Current job and result index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else begin
      if (job_take) begin
        cur_vld_r <= 1'b1;
        idx_r     <= 2'd0;
      end else if (cur_vld_r && out_load) begin
        if (at_end) begin
          cur_vld_r <= 1'b0;
          idx_r     <= 2'd0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur_r <= job_in;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= cur_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && cur_vld_r) begin
      char_r     <= cur_r.data[idx_r];
      has_r      <= cur_r.has;
      run_last_r <= at_end;
      msg_end_r  <= at_end && cur_r.msg_end;
    end
  end

  assign empty           = !out_vld_r;
  assign out_char        = char_r;
  assign out_has_data    = has_r;
  assign out_run_last    = run_last_r;
  assign out_message_end = msg_end_r;

  // A job in progress never points past its last result.
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> ({1'b0, idx_r} < cur_r.cnt))
    else $error("result index past the job");

  // A result without data always closes the message.
  a_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !has_r) |-> (run_last_r && msg_end_r))
    else $error("empty result that does not close the message");

endmodule

// ----- rtl/base64_codec_core.sv -----
// ----------------------------------------------------------------------------
// base64_codec_core
// Standard-alphabet base64 encoder and decoder with a direction register.
//
//   Channel   Handshake            Payload
//   input     push / full          in_char, in_last
//   result    empty / pop          out_char, out_has_data, out_run_last,
//                                  out_message_end
//   config    cfg_valid/cfg_ready  cfg_data (direction, 0 encode, 1 decode)
//
// An item's job passes the job queue and the current-job and output registers.
// The back hands out one result per cycle unless pop stalls, so encoding
// sustains three items per four results and decoding four items per three.
// A two-entry job queue lets the front keep taking items while results stall.
// Reset is synchronous and active low; it selects encoding and clears all
// groups. A direction write also drops any message in progress.
// ----------------------------------------------------------------------------
module base64_codec_core import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       out_has_data,
  output logic       out_run_last,
  output logic       out_message_end
);

  job_t job_wr, job_rd;
  logic job_push, job_take, job_full, job_avail;
  logic cfg_wr, accept;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign full      = job_full;
  assign accept    = push && !full;

  // Front: classification and group state.
  b64_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .cfg_dir  (cfg_data),
    .accept   (accept),
    .in_char  (in_char),
    .in_last  (in_last),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_wr)
  );

  // Job queue.
  b64_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .wr_job   (job_wr),
    .pop      (job_take),
    .rd_job   (job_rd),
    .full     (job_full),
    .nonempty (job_avail)
  );

  // Back: result sequencing.
  b64_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_avail       (job_avail),
    .job_in          (job_rd),
    .job_take        (job_take),
    .pop             (pop),
    .empty           (empty),
    .out_char        (out_char),
    .out_has_data    (out_has_data),
    .out_run_last    (out_run_last),
    .out_message_end (out_message_end)
  );

endmodule

// ----- verif/base64_codec_core_tb.sv -----
// ----------------------------------------------------------------------------
// base64_codec_core_tb
// Self-checking bench for the base64 codec core. Items are pushed in bursts
// from a pending queue and results are popped under changing stall patterns.
// A built-in codec model predicts every result, which is checked in order.
// The run covers both directions, padding, stop characters and message drops.
// ----------------------------------------------------------------------------
module base64_codec_core_tb;
  import b64_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    SETTLE_CYCLES  = 8;
  localparam int    HOLD_CYCLES    = 120;
  localparam int    MAX_PRINTS     = 40;
  localparam string B64_ALPHABET   =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       run_last;
    logic       msg_end;
  } codec_out_t;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data  = 1'b0;
  logic       push      = 1'b0;
  logic       full;
  logic [7:0] in_char   = 8'h00;
  logic       in_last   = 1'b0;
  logic       empty;
  logic       pop       = 1'b0;
  logic [7:0] out_char;
  logic       out_has_data;
  logic       out_run_last;
  logic       out_message_end;

  // Items waiting to be pushed, and results the model says must come out.
  char_item_t input_chars[$];
  codec_out_t predicted_out[$];

  // Model state and direction register copy.
  logic        dir_mode    = DIR_ENCODE;
  logic [1:0]  grp_fill    = 2'd0;
  logic [17:0] grp_bits    = 18'd0;
  logic        dec_stopped = 1'b0;

  int   mismatches = 0;
  int   burst_left = 4;
  int   gap_left   = 0;
  int   rx_mode    = 0;
  int   rx_left    = 0;
  int   rx_cycle   = 0;
  int   idle_count = 0;
  logic hold_go    = 1'b0;
  logic hold_off   = 1'b0;

  base64_codec_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .in_char         (in_char),
    .in_last         (in_last),
    .empty           (empty),
    .pop             (pop),
    .out_char        (out_char),
    .out_has_data    (out_has_data),
    .out_run_last    (out_run_last),
    .out_message_end (out_message_end)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Alphabet lookups; a return of -1 marks padding or an unknown character.
  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    return B64_ALPHABET[s];
  endfunction

  function automatic int char_sextet(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "a" && c <= "z") return int'(c - "a") + 26;
    if (c >= "0" && c <= "9") return int'(c - "0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  // Unpack nb bytes from k sextets, left-aligned in a 24-bit word.
  function automatic void emit_bytes(ref codec_out_t res[$], input logic [23:0] acc,
                                     input int k, input int nb);
    logic [23:0] v;
    codec_out_t  r;
    v = acc << (6 * (4 - k));
    for (int i = 0; i < nb; i++) begin
      r = '{ch: v[23 - 8 * i -: 8], has: 1'b1, run_last: 1'b0, msg_end: 1'b0};
      res.push_back(r);
    end
  endfunction

  function automatic void clear_groups();
    grp_fill    = 2'd0;
    grp_bits    = 18'd0;
    dec_stopped = 1'b0;
  endfunction

  // Predict the results of one accepted item and update the model state.
  function automatic void codec_step(input logic [7:0] c, input logic last_in);
    codec_out_t  res[$];
    codec_out_t  r;
    logic [23:0] acc;
    logic [23:0] v;
    int          cnt;
    int          k;
    int          sx;
    if (dir_mode == DIR_ENCODE) begin
      // Encoding: hold bytes until three are in or the message ends.
      cnt = ((grp_fill > 2'd2) ? 2 : int'(grp_fill)) + 1;
      acc = {grp_bits[15:0], c};
      if (cnt < 3 && !last_in) begin
        grp_bits = acc[17:0];
        grp_fill = 2'(cnt);
        return;
      end
      v = acc << (8 * (3 - cnt));
      for (int i = 0; i < 4; i++) begin
        r.ch       = (i <= cnt) ? sextet_char(v[23 - 6 * i -: 6]) : PAD_CHAR;
        r.has      = 1'b1;
        r.run_last = 1'b0;
        r.msg_end  = 1'b0;
        res.push_back(r);
      end
      grp_fill = 2'd0;
      grp_bits = 18'd0;
    end else if (!dec_stopped) begin
      sx = char_sextet(c);
      if (sx < 0) begin
        // Padding or a foreign character flushes the partial group and stops.
        k = int'(grp_fill);
        if (k >= 2) emit_bytes(res, {6'd0, grp_bits}, k, k - 1);
        grp_fill    = 2'd0;
        grp_bits    = 18'd0;
        dec_stopped = 1'b1;
      end else begin
        acc = {grp_bits, 6'(sx)};
        k   = int'(grp_fill) + 1;
        if (k == 4) begin
          emit_bytes(res, acc, 4, 3);
          grp_fill = 2'd0;
          grp_bits = 18'd0;
        end else if (!last_in) begin
          grp_bits = acc[17:0];
          grp_fill = 2'(k);
          return;
        end else begin
          emit_bytes(res, acc, k, k - 1);
        end
      end
    end
    // A message end always yields a result, even without data.
    if (last_in && res.size() == 0) begin
      r = '{ch: 8'h00, has: 1'b0, run_last: 1'b0, msg_end: 1'b0};
      res.push_back(r);
    end
    if (res.size() > 0) begin
      res[res.size() - 1].run_last = 1'b1;
      if (last_in) res[res.size() - 1].msg_end = 1'b1;
    end
    if (last_in) clear_groups();
    foreach (res[i]) predicted_out.push_back(res[i]);
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < MAX_PRINTS)
      $display("%0t: %s got %h, expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Stimulus helpers.
  function automatic void add_item(input logic [7:0] c, input logic last_in);
    char_item_t it;
    it = '{ch: c, last: last_in};
    input_chars.push_back(it);
  endfunction

  function automatic void add_text(input string s, input logic end_msg);
    for (int i = 0; i < s.len(); i++) add_item(s[i], end_msg && (i == s.len() - 1));
  endfunction

  function automatic void add_random_bytes_msg();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) add_item(8'($urandom_range(0, 255)), i == n - 1);
  endfunction

  // Mostly well-formed text; some with a foreign character, noise or early padding.
  function automatic void add_random_text_msg();
    logic [7:0] chars[$];
    logic [7:0] bad;
    int         n;
    int         form;
    n    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
    form = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) chars.push_back(sextet_char(6'($urandom_range(0, 63))));
    if (form <= 5) begin
      if (n % 4 == 2) begin
        chars.push_back(PAD_CHAR);
        chars.push_back(PAD_CHAR);
      end else if (n % 4 == 3) begin
        chars.push_back(PAD_CHAR);
      end
    end else if (form <= 7) begin
      do bad = 8'($urandom_range(0, 255)); while (char_sextet(bad) >= 0);
      chars.insert($urandom_range(0, n - 1), bad);
    end else if (form == 8) begin
      foreach (chars[i]) chars[i] = 8'($urandom_range(0, 255));
    end else begin
      chars.insert($urandom_range(0, n - 1), PAD_CHAR);
    end
    foreach (chars[i]) add_item(chars[i], i == chars.size() - 1);
  endfunction

  // Wait until every item is in and every result is out, then let it settle.
  task automatic wait_quiet();
    while (input_chars.size() != 0 || predicted_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_direction(input logic d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    dir_mode = d;
    clear_groups();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Input driver: offer the head of the queue, pausing between bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      push <= 1'b0;
    end else if (input_chars.size() > 0) begin
      push    <= 1'b1;
      in_char <= input_chars[0].ch;
      in_last <= input_chars[0].last;
    end else begin
      push <= 1'b0;
    end
  end

  // Result receiver: switches between free flow, random stalls and a fixed rhythm.
  always @(negedge clk) begin
    logic take;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(16, 64);
    end
    rx_left--;
    rx_cycle++;
    case (rx_mode)
      0:       take = 1'b1;
      1:       take = 1'($urandom_range(0, 1));
      default: take = (rx_cycle % 3) != 0;
    endcase
    pop <= rst_n && take && !hold_off;
  end

  // Long receiver hold-off so the core fills up and pushes back.
  initial begin
    wait (hold_go);
    repeat (10) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Monitor: predict on each accepted item and check each accepted result.
  always @(posedge clk) begin
    codec_out_t want;
    if (rst_n) begin
      if (push && !full) begin
        codec_step(input_chars[0].ch, input_chars[0].last);
        void'(input_chars.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (pop && !empty) begin
        if (predicted_out.size() == 0) begin
          report_mismatch("unexpected out_char", out_char, 8'h00);
        end else begin
          want = predicted_out.pop_front();
          if (out_char !== want.ch) report_mismatch("out_char", out_char, want.ch);
          if (out_has_data !== want.has)
            report_mismatch("out_has_data", 8'(out_has_data), 8'(want.has));
          if (out_run_last !== want.run_last)
            report_mismatch("out_run_last", 8'(out_run_last), 8'(want.run_last));
          if (out_message_end !== want.msg_end)
            report_mismatch("out_message_end", 8'(out_message_end), 8'(want.msg_end));
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item, result or register write.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed encoding: one, two and three byte messages, the byte extremes among them.
    set_direction(DIR_ENCODE);
    add_item(8'h00, 1'b1);
    add_item(8'hff, 1'b0);
    add_item(8'h80, 1'b1);
    add_item(8'h00, 1'b0);
    add_item(8'hff, 1'b0);
    add_item(8'h5a, 1'b1);
    // A partial message that the direction write must drop.
    add_item(8'h12, 1'b0);
    add_item(8'h34, 1'b0);
    wait_quiet();

    // Directed decoding: full groups, alphabet edges, padding, foreign
    // characters, a lone held character and items after a stop.
    set_direction(DIR_DECODE);
    add_text("A/+z", 1'b0);
    add_text("Za09", 1'b1);
    add_text("QQ==", 1'b1);
    add_text("Q", 1'b1);
    add_text("QUJ", 1'b0);
    add_item(8'hff, 1'b0);
    add_item("A", 1'b1);
    add_item(8'h00, 1'b1);
    wait_quiet();

    // Random encoding, with the receiver held off for a while.
    set_direction(DIR_ENCODE);
    while (input_chars.size() < 60) add_random_bytes_msg();
    hold_go = 1'b1;
    wait_quiet();

    // Random decoding, ending with a partial group that gets dropped.
    set_direction(DIR_DECODE);
    while (input_chars.size() < 75) add_random_text_msg();
    add_text("QU", 1'b0);
    wait_quiet();

    set_direction(DIR_ENCODE);
    while (input_chars.size() < 15) add_random_bytes_msg();
    wait_quiet();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
